/* design/sset_pkg.sv */
// Shared types and constants of the sparse-set entity store.
package sset_pkg;

	localparam int ENTITY_SLOTS = 1024;
	localparam int DENSE_SLOTS  = 1024;
	localparam int DATA_BITS    = 32;
	localparam int FUNC_BITS    = 3;
	localparam int ENT_IN_BITS  = 12;
	localparam int LIMIT_BITS   = 11;
	localparam int STATUS_BITS  = 2;
	localparam int ENT_BITS     = $clog2(ENTITY_SLOTS);
	localparam int SLOT_BITS    = $clog2(DENSE_SLOTS);
	localparam int COUNT_BITS   = SLOT_BITS + 1;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [FUNC_BITS-1:0] FUNC_ADD    = 3'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 3'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_QUERY  = 3'd2;
	localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 3'd3;
	localparam logic [FUNC_BITS-1:0] FUNC_COPY   = 3'd4;

	localparam logic [STATUS_BITS-1:0] STAT_DONE  = 2'd0;
	localparam logic [STATUS_BITS-1:0] STAT_NONE  = 2'd1;
	localparam logic [STATUS_BITS-1:0] STAT_RANGE = 2'd2;
	localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd3;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_REMOVE,
		OP_QUERY,
		OP_CLEAR,
		OP_COPY,
		OP_NONE,
		OP_RANGE
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [ENT_BITS-1:0]  ent;
		logic [ENT_BITS-1:0]  src;
		logic [DATA_BITS-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

endpackage

/* design/sset_intf.sv */
// Request, response and configuration channel interfaces.
interface sset_req_if;
	import sset_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [FUNC_BITS-1:0]   func;
	logic [ENT_IN_BITS-1:0] entity;
	logic [ENT_IN_BITS-1:0] source_entity;
	logic                   has_data;
	logic [DATA_BITS-1:0]   item_data;
	modport source (output valid, func, entity, source_entity, has_data, item_data,
		input ready);
	modport sink (input valid, func, entity, source_entity, has_data, item_data,
		output ready);
endinterface

interface sset_rsp_if;
	import sset_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [STATUS_BITS-1:0] status;
	logic                   found;
	logic [DATA_BITS-1:0]   stored_data;
	logic [SLOT_BITS-1:0]   dense_slot;
	logic [COUNT_BITS-1:0]  member_count;
	modport source (output valid, status, found, stored_data, dense_slot, member_count,
		input ready);
	modport sink (input valid, status, found, stored_data, dense_slot, member_count,
		output ready);
endinterface

interface sset_cfg_if;
	import sset_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [LIMIT_BITS-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* design/sset_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sset_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_BITS = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/sset_front.sv */
// Front end: limit register, range check and request classification.
module sset_front (
	input  logic             clk,
	input  logic             arst_n,
	sset_cfg_if.sink         cfg,
	sset_req_if.sink         req,
	input  sset_pkg::q_stat_t qstat,
	output logic             push,
	output sset_pkg::cmd_t   cmd
);
	import sset_pkg::*;

	logic [LIMIT_BITS-1:0] limit_q;
	logic [LIMIT_BITS-1:0] lim_eff;
	logic                  ent_ok;
	logic                  src_ok;
	op_t                   op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_BITS'(ENTITY_SLOTS);
		end else if (cfg.valid && cfg.ready) begin
			limit_q <= cfg.data;
		end
	end

	assign cfg.ready = 1'b1;

	// Clamp the limit to the sparse map size
	assign lim_eff = (limit_q > LIMIT_BITS'(ENTITY_SLOTS)) ? LIMIT_BITS'(ENTITY_SLOTS) : limit_q;
	assign ent_ok  = req.entity < ENT_IN_BITS'(lim_eff);
	assign src_ok  = req.source_entity < ENT_IN_BITS'(lim_eff);

	always_comb begin
		unique case (req.func)
			FUNC_ADD:    op = OP_ADD;
			FUNC_REMOVE: op = OP_REMOVE;
			FUNC_QUERY:  op = OP_QUERY;
			FUNC_CLEAR:  op = OP_CLEAR;
			FUNC_COPY:   op = OP_COPY;
			default:     op = OP_NONE;
		endcase
		if (!ent_ok || (op == OP_COPY && !src_ok)) begin
			op = OP_RANGE;
		end
	end

	assign req.ready = !qstat.full;
	assign push      = req.valid && req.ready;
	assign cmd.op    = op;
	assign cmd.ent   = req.entity[ENT_BITS-1:0];
	assign cmd.src   = req.source_entity[ENT_BITS-1:0];
	assign cmd.data  = req.has_data ? req.item_data : '0;

endmodule

/* design/sset_queue.sv */
// Short command queue between the front and back ends.
module sset_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sset_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output sset_pkg::cmd_t    head,
	output sset_pkg::q_stat_t stat
);
	import sset_pkg::*;

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	cmd_t                entries_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign head          = entries_q[rd_ptr_q];
	assign stat.full     = count_q == CNT_BITS'(QUEUE_DEPTH);
	assign stat.nonempty = count_q != '0;

endmodule

/* design/sset_back.sv */
// Back end: sequencer over the sparse map, owner and data memories.
module sset_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sset_pkg::q_stat_t qstat,
	input  sset_pkg::cmd_t    head,
	output logic              pop,
	sset_rsp_if.source        rsp
);
	import sset_pkg::*;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SLOTA,
		ST_PRESA,
		ST_PRESB,
		ST_EXEC
	} state_t;

	state_t                 state_q;
	cmd_t                   cmd_q;
	logic [COUNT_BITS-1:0]  held_q;
	logic [ENT_BITS-1:0]    clr_addr_q;
	logic [SLOT_BITS-1:0]   slot_a_q;
	logic [SLOT_BITS-1:0]   slot_b_q;
	logic                   pres_a_q;
	logic                   pres_b_q;
	logic [DATA_BITS-1:0]   data_a_q;
	logic [DATA_BITS-1:0]   data_b_q;
	logic                   rsp_valid_q;
	logic [STATUS_BITS-1:0] status_q;
	logic                   found_q;
	logic [DATA_BITS-1:0]   stored_q;
	logic [SLOT_BITS-1:0]   dense_q;

	// memory ports
	logic [ENT_BITS-1:0]  map_raddr;
	logic [SLOT_BITS-1:0] map_rd;
	logic                 map_we;
	logic [ENT_BITS-1:0]  map_waddr;
	logic [SLOT_BITS-1:0] map_wdata;
	logic [SLOT_BITS-1:0] own_raddr;
	logic [ENT_BITS-1:0]  own_rd;
	logic                 own_we;
	logic [SLOT_BITS-1:0] own_waddr;
	logic [ENT_BITS-1:0]  own_wdata;
	logic                 dat_we;
	logic [SLOT_BITS-1:0] dat_waddr;
	logic [DATA_BITS-1:0] dat_wdata;
	logic [DATA_BITS-1:0] dat_rd;

	logic [SLOT_BITS-1:0]   last_slot;
	logic [SLOT_BITS-1:0]   held_slot;
	logic [ENT_BITS-1:0]    key_a;
	logic [ENT_BITS-1:0]    cmp_key;
	logic [SLOT_BITS-1:0]   cmp_slot;
	logic                   hit;
	logic                   full;
	logic                   fire;
	logic                   do_add;
	logic [DATA_BITS-1:0]   add_data;
	logic [COUNT_BITS-1:0]  new_held;
	logic [STATUS_BITS-1:0] r_status;
	logic                   r_found;
	logic [SLOT_BITS-1:0]   r_slot;
	logic [DATA_BITS-1:0]   r_data;
	logic                   w_map;
	logic                   w_own;
	logic                   w_dat;

	sset_ram #(.WIDTH(SLOT_BITS), .DEPTH(ENTITY_SLOTS)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rd)
	);

	sset_ram #(.WIDTH(ENT_BITS), .DEPTH(DENSE_SLOTS)) u_owner (
		.clk   (clk),
		.we    (own_we),
		.waddr (own_waddr),
		.wdata (own_wdata),
		.raddr (own_raddr),
		.rdata (own_rd)
	);

	sset_ram #(.WIDTH(DATA_BITS), .DEPTH(DENSE_SLOTS)) u_data (
		.clk   (clk),
		.we    (dat_we),
		.waddr (dat_waddr),
		.wdata (dat_wdata),
		.raddr (own_raddr),
		.rdata (dat_rd)
	);

	assign last_slot = SLOT_BITS'(held_q - COUNT_BITS'(1));
	assign held_slot = held_q[SLOT_BITS-1:0];
	assign key_a     = (cmd_q.op == OP_COPY) ? cmd_q.src : cmd_q.ent;
	assign full      = held_q == COUNT_BITS'(DENSE_SLOTS);
	assign pop       = (state_q == ST_IDLE) && qstat.nonempty;
	assign fire      = (state_q == ST_EXEC) && (!rsp_valid_q || rsp.ready);

	// Present only if the slot is live and points back at the entity;
	// this makes stale sparse map entries harmless.
	assign cmp_key  = (state_q == ST_PRESB) ? cmd_q.ent : key_a;
	assign cmp_slot = (state_q == ST_PRESB) ? slot_b_q : slot_a_q;
	assign hit      = (own_rd == cmp_key) && (COUNT_BITS'(cmp_slot) < held_q);

	always_comb begin
		if (state_q == ST_IDLE) begin
			map_raddr = (head.op == OP_COPY) ? head.src : head.ent;
		end else begin
			map_raddr = cmd_q.ent;
		end
		if (state_q == ST_SLOTA) begin
			own_raddr = map_rd;
		end else if (state_q == ST_PRESA && cmd_q.op == OP_COPY) begin
			own_raddr = map_rd;
		end else begin
			// hold on the last slot for a remove, also while stalled
			own_raddr = last_slot;
		end
	end

	always_comb begin
		do_add    = 1'b0;
		add_data  = cmd_q.data;
		w_map     = 1'b0;
		w_own     = 1'b0;
		w_dat     = 1'b0;
		map_waddr = cmd_q.ent;
		map_wdata = held_slot;
		own_waddr = held_slot;
		own_wdata = cmd_q.ent;
		dat_waddr = held_slot;
		dat_wdata = cmd_q.data;
		new_held  = held_q;
		r_status  = STAT_NONE;
		r_found   = pres_b_q;
		r_slot    = slot_b_q;
		r_data    = data_b_q;
		unique case (cmd_q.op)
			OP_ADD: begin
				if (!pres_b_q) begin
					if (full) begin
						r_status = STAT_FULL;
					end else begin
						do_add = 1'b1;
					end
				end
			end
			OP_REMOVE: begin
				if (pres_b_q) begin
					// move the last entry into the hole
					w_dat     = 1'b1;
					dat_waddr = slot_b_q;
					dat_wdata = dat_rd;
					w_own     = 1'b1;
					own_waddr = slot_b_q;
					own_wdata = own_rd;
					w_map     = 1'b1;
					map_waddr = own_rd;
					map_wdata = slot_b_q;
					new_held  = held_q - COUNT_BITS'(1);
					r_found   = 1'b0;
					r_status  = STAT_DONE;
				end
			end
			OP_QUERY: begin
				r_status = pres_b_q ? STAT_DONE : STAT_NONE;
			end
			OP_CLEAR: begin
				if (pres_b_q) begin
					w_dat     = 1'b1;
					dat_waddr = slot_b_q;
					dat_wdata = '0;
					r_data    = '0;
					r_status  = STAT_DONE;
				end
			end
			OP_COPY: begin
				if (pres_a_q) begin
					add_data = data_a_q;
					if (pres_b_q) begin
						w_dat     = 1'b1;
						dat_waddr = slot_b_q;
						dat_wdata = data_a_q;
						r_data    = data_a_q;
						r_status  = STAT_DONE;
					end else if (full) begin
						r_status = STAT_FULL;
					end else begin
						do_add = 1'b1;
					end
				end
			end
			OP_NONE: begin
				r_status = STAT_NONE;
			end
			OP_RANGE: begin
				r_status = STAT_RANGE;
				r_found  = 1'b0;
			end
			default: begin
				r_status = STAT_NONE;
			end
		endcase
		if (do_add) begin
			// append at the end of the dense store
			w_dat     = 1'b1;
			dat_waddr = held_slot;
			dat_wdata = add_data;
			w_own     = 1'b1;
			own_waddr = held_slot;
			own_wdata = cmd_q.ent;
			w_map     = 1'b1;
			map_waddr = cmd_q.ent;
			map_wdata = held_slot;
			new_held  = held_q + COUNT_BITS'(1);
			r_found   = 1'b1;
			r_slot    = held_slot;
			r_data    = add_data;
			r_status  = STAT_DONE;
		end
		if (!r_found) begin
			r_slot = '0;
			r_data = '0;
		end
		// sweep the sparse map after reset
		if (state_q == ST_INIT) begin
			map_waddr = clr_addr_q;
			map_wdata = '0;
		end
	end

	assign map_we = (state_q == ST_INIT) || (fire && w_map);
	assign own_we = fire && w_own;
	assign dat_we = fire && w_dat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cmd_q       <= '0;
			held_q      <= '0;
			clr_addr_q  <= '0;
			slot_a_q    <= '0;
			slot_b_q    <= '0;
			pres_a_q    <= 1'b0;
			pres_b_q    <= 1'b0;
			data_a_q    <= '0;
			data_b_q    <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= STAT_DONE;
			found_q     <= 1'b0;
			stored_q    <= '0;
			dense_q     <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready && !fire) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					clr_addr_q <= clr_addr_q + ENT_BITS'(1);
					if (clr_addr_q == ENT_BITS'(ENTITY_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (qstat.nonempty) begin
						cmd_q   <= head;
						state_q <= ST_SLOTA;
					end
				end
				ST_SLOTA: begin
					slot_a_q <= map_rd;
					state_q  <= ST_PRESA;
				end
				ST_PRESA: begin
					pres_a_q <= hit;
					data_a_q <= dat_rd;
					if (cmd_q.op == OP_COPY) begin
						slot_b_q <= map_rd;
						state_q  <= ST_PRESB;
					end else begin
						slot_b_q <= slot_a_q;
						pres_b_q <= hit;
						data_b_q <= dat_rd;
						state_q  <= ST_EXEC;
					end
				end
				ST_PRESB: begin
					pres_b_q <= hit;
					data_b_q <= dat_rd;
					state_q  <= ST_EXEC;
				end
				ST_EXEC: begin
					if (fire) begin
						held_q      <= new_held;
						rsp_valid_q <= 1'b1;
						status_q    <= r_status;
						found_q     <= r_found;
						stored_q    <= r_data;
						dense_q     <= r_slot;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.found        = found_q;
	assign rsp.stored_data  = stored_q;
	assign rsp.dense_slot   = dense_q;
	assign rsp.member_count = held_q;

endmodule

/* design/sparse_set_entity_store.sv */
// A taken request waits in the queue; the back end then steps IDLE, SLOTA, PRESA, PRESB (copy only)
// and EXEC, registering the result. The back-end sequencer works on one request at a time, stepping
// sparse map, owner and data memories that each give one registered read a cycle; it starts no new one before that.
// Two requests queue between front and back; the response register frees the back end early.
// Reset: member count zero, entity limit 1024; the back end then sweeps the sparse map,
// queuing up to two requests but starting none until the sweep ends.
module sparse_set_entity_store (
	input  logic        clk,
	input  logic        arst_n,
	sset_cfg_if.sink    cfg,
	sset_req_if.sink    req,
	sset_rsp_if.source  rsp
);
	import sset_pkg::*;

	logic    push;
	cmd_t    push_cmd;
	logic    pop;
	cmd_t    head;
	q_stat_t qstat;

	sset_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.qstat  (qstat),
		.push   (push),
		.cmd    (push_cmd)
	);

	sset_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	sset_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.member_count <= COUNT_BITS'(DENSE_SLOTS))
		else $error("member count beyond dense store size");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> rsp.dense_slot == '0 && rsp.stored_data == '0)
		else $error("absent entity reports slot or data");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STAT_FULL
		|-> rsp.member_count == COUNT_BITS'(DENSE_SLOTS) && !rsp.found)
		else $error("full status while store not full");

	a_slot_live: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> COUNT_BITS'(rsp.dense_slot) < rsp.member_count)
		else $error("found entity at a slot past the member count");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for the sparse-set entity store: directed table, then random phases.
module tb_top;
	import sset_pkg::*;

	localparam logic [FUNC_BITS-1:0] FUNC_SPARE_LO  = 3'd5;
	localparam logic [FUNC_BITS-1:0] FUNC_SPARE_MID = 3'd6;
	localparam logic [FUNC_BITS-1:0] FUNC_SPARE_HI  = 3'd7;
	localparam logic [COUNT_BITS-1:0] MAP_EMPTY = '1;
	localparam int POST_DRAIN_CYCLES = 16;
	localparam int STALL_LIMIT = 5000;
	localparam int FILL_ITEMS = 300;

	typedef struct packed {
		logic [FUNC_BITS-1:0]   func;
		logic [ENT_IN_BITS-1:0] entity;
		logic [ENT_IN_BITS-1:0] source_entity;
		logic                   has_data;
		logic [DATA_BITS-1:0]   item_data;
	} sset_req_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic                   found;
		logic [DATA_BITS-1:0]   stored_data;
		logic [SLOT_BITS-1:0]   dense_slot;
		logic [COUNT_BITS-1:0]  member_count;
	} sset_rsp_t;

	typedef struct packed {
		sset_req_t req;
		logic      typed;
		sset_rsp_t rsp;
	} dir_row_t;

	localparam sset_rsp_t NO_RSP = '0;

	logic clk;
	logic arst_n;

	sset_cfg_if cfg_ch();
	sset_req_if req_ch();
	sset_rsp_if rsp_ch();

	sparse_set_entity_store dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Shadow copy of the store
	logic [COUNT_BITS-1:0] sparse_map [ENTITY_SLOTS];
	logic [ENT_BITS-1:0]   dense_owner [DENSE_SLOTS];
	logic [DATA_BITS-1:0]  dense_data [DENSE_SLOTS];
	logic [COUNT_BITS-1:0] held;
	logic [LIMIT_BITS-1:0] limit_reg;

	sset_rsp_t expected_rsp_q [$];
	int errors = 0;
	int idle_pct = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	dir_row_t directed_rows [24] = '{
		// fresh store: query and remove find nothing
		'{'{FUNC_QUERY, 12'd0, 12'd0, 1'b0, 32'h0}, 1'b1,
			'{STAT_NONE, 1'b0, 32'h0, 10'd0, 11'd0}},
		'{'{FUNC_REMOVE, 12'd5, 12'd0, 1'b1, 32'h0}, 1'b1,
			'{STAT_NONE, 1'b0, 32'h0, 10'd0, 11'd0}},
		'{'{FUNC_ADD, 12'd0, 12'd0, 1'b1, 32'hFFFF_FFFF}, 1'b1,
			'{STAT_DONE, 1'b1, 32'hFFFF_FFFF, 10'd0, 11'd1}},
		'{'{FUNC_ADD, 12'd1023, 12'd4095, 1'b0, 32'h1234_5678}, 1'b1,
			'{STAT_DONE, 1'b1, 32'h0, 10'd1, 11'd2}},
		// add when present leaves the data alone
		'{'{FUNC_ADD, 12'd0, 12'd0, 1'b1, 32'h0}, 1'b1,
			'{STAT_NONE, 1'b1, 32'hFFFF_FFFF, 10'd0, 11'd2}},
		'{'{FUNC_ADD, 12'd1024, 12'd0, 1'b1, 32'h1}, 1'b1,
			'{STAT_RANGE, 1'b0, 32'h0, 10'd0, 11'd2}},
		'{'{FUNC_QUERY, 12'd4095, 12'd0, 1'b0, 32'h0}, 1'b1,
			'{STAT_RANGE, 1'b0, 32'h0, 10'd0, 11'd2}},
		'{'{FUNC_COPY, 12'd7, 12'd4095, 1'b0, 32'h0}, 1'b1,
			'{STAT_RANGE, 1'b0, 32'h0, 10'd0, 11'd2}},
		'{'{FUNC_ADD, 12'd7, 12'd0, 1'b1, 32'hA5A5_A5A5}, 1'b0, NO_RSP},
		'{'{FUNC_COPY, 12'd1023, 12'd0, 1'b0, 32'h0}, 1'b0, NO_RSP},
		'{'{FUNC_COPY, 12'd20, 12'd7, 1'b0, 32'h0}, 1'b0, NO_RSP},
		'{'{FUNC_COPY, 12'd7, 12'd500, 1'b1, 32'hFFFF_FFFF}, 1'b0, NO_RSP},
		'{'{FUNC_COPY, 12'd7, 12'd7, 1'b0, 32'h0}, 1'b0, NO_RSP},
		'{'{FUNC_CLEAR, 12'd7, 12'd0, 1'b0, 32'h0}, 1'b0, NO_RSP},
		'{'{FUNC_CLEAR, 12'd300, 12'd0, 1'b0, 32'h0}, 1'b0, NO_RSP},
		'{'{FUNC_COPY, 12'd21, 12'd20, 1'b0, 32'h0}, 1'b0, NO_RSP},
		// remove from the front pulls the last entry into the hole
		'{'{FUNC_REMOVE, 12'd0, 12'd0, 1'b0, 32'h0}, 1'b0, NO_RSP},
		'{'{FUNC_QUERY, 12'd21, 12'd0, 1'b0, 32'h0}, 1'b0, NO_RSP},
		'{'{FUNC_REMOVE, 12'd20, 12'd0, 1'b0, 32'h0}, 1'b0, NO_RSP},
		'{'{FUNC_SPARE_LO, 12'd1023, 12'd0, 1'b1, 32'h5A5A_5A5A}, 1'b0, NO_RSP},
		'{'{FUNC_SPARE_MID, 12'd7, 12'd4095, 1'b0, 32'h0}, 1'b0, NO_RSP},
		'{'{FUNC_SPARE_HI, 12'd3000, 12'd0, 1'b1, 32'hFFFF_FFFF}, 1'b0, NO_RSP},
		'{'{FUNC_REMOVE, 12'd1023, 12'd0, 1'b0, 32'h0}, 1'b0, NO_RSP},
		'{'{FUNC_QUERY, 12'd1023, 12'd0, 1'b0, 32'h0}, 1'b0, NO_RSP}
	};

	function automatic bit is_held(int e);
		return sparse_map[e] != MAP_EMPTY && sparse_map[e] < held;
	endfunction

	function automatic logic [STATUS_BITS-1:0] append_entity(int e, logic [DATA_BITS-1:0] d);
		if (held >= DENSE_SLOTS)
			return STAT_FULL;
		dense_data[held] = d;
		dense_owner[held] = e[ENT_BITS-1:0];
		sparse_map[e] = held;
		held = held + 1'b1;
		return STAT_DONE;
	endfunction

	task automatic predict_request(input sset_req_t r, output sset_rsp_t o);
		int lim;
		int e;
		int src;
		logic [STATUS_BITS-1:0] st;
		logic [COUNT_BITS-1:0] slot;
		logic [COUNT_BITS-1:0] last;
		logic [ENT_BITS-1:0] moved;
		logic [DATA_BITS-1:0] v;
		lim = (limit_reg > ENTITY_SLOTS) ? ENTITY_SLOTS : int'(limit_reg);
		e = int'(r.entity);
		src = int'(r.source_entity);
		o = '0;
		st = STAT_NONE;
		if (e >= lim || (r.func == FUNC_COPY && src >= lim)) begin
			st = STAT_RANGE;
		end else begin
			case (r.func)
				FUNC_ADD: begin
					if (!is_held(e))
						st = append_entity(e, r.has_data ? r.item_data : '0);
				end
				FUNC_REMOVE: begin
					if (is_held(e)) begin
						slot = sparse_map[e];
						last = held - 1'b1;
						if (slot != last) begin
							moved = dense_owner[last];
							dense_data[slot] = dense_data[last];
							dense_owner[slot] = moved;
							sparse_map[moved] = slot;
						end
						sparse_map[e] = MAP_EMPTY;
						held = last;
						st = STAT_DONE;
					end
				end
				FUNC_QUERY: st = is_held(e) ? STAT_DONE : STAT_NONE;
				FUNC_CLEAR: begin
					if (is_held(e)) begin
						dense_data[sparse_map[e]] = '0;
						st = STAT_DONE;
					end
				end
				FUNC_COPY: begin
					if (is_held(src)) begin
						v = dense_data[sparse_map[src]];
						if (is_held(e)) begin
							dense_data[sparse_map[e]] = v;
							st = STAT_DONE;
						end else begin
							st = append_entity(e, v);
						end
					end
				end
				default: st = STAT_NONE;
			endcase
			if (is_held(e)) begin
				o.found = 1'b1;
				o.dense_slot = sparse_map[e][SLOT_BITS-1:0];
				o.stored_data = dense_data[sparse_map[e]];
			end
		end
		o.status = st;
		o.member_count = held;
	endtask

	task automatic check_result(input sset_rsp_t exp_r, input sset_rsp_t act);
		if (act.status !== exp_r.status) begin
			$display("%0t: status expected %0d got %0d", $time, exp_r.status, act.status);
			errors++;
		end
		if (act.found !== exp_r.found) begin
			$display("%0t: found expected %0d got %0d", $time, exp_r.found, act.found);
			errors++;
		end
		if (act.stored_data !== exp_r.stored_data) begin
			$display("%0t: stored_data expected %h got %h", $time, exp_r.stored_data,
				act.stored_data);
			errors++;
		end
		if (act.dense_slot !== exp_r.dense_slot) begin
			$display("%0t: dense_slot expected %0d got %0d", $time, exp_r.dense_slot,
				act.dense_slot);
			errors++;
		end
		if (act.member_count !== exp_r.member_count) begin
			$display("%0t: member_count expected %0d got %0d", $time, exp_r.member_count,
				act.member_count);
			errors++;
		end
	endtask

	// Response side: check each transaction, then stall in random bursts
	initial begin
		sset_rsp_t act;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				act = '{rsp_ch.status, rsp_ch.found, rsp_ch.stored_data, rsp_ch.dense_slot,
					rsp_ch.member_count};
				if (expected_rsp_q.size() == 0) begin
					$display("%0t: unexpected response, expected none, got %h", $time, act);
					errors++;
				end else begin
					check_result(expected_rsp_q.pop_front(), act);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(0, 11);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send_request(input sset_req_t r, input logic typed, input sset_rsp_t typed_rsp);
		sset_rsp_t pred;
		req_ch.valid <= 1'b1;
		req_ch.func <= r.func;
		req_ch.entity <= r.entity;
		req_ch.source_entity <= r.source_entity;
		req_ch.has_data <= r.has_data;
		req_ch.item_data <= r.item_data;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predict_request(r, pred);
		expected_rsp_q.push_back(typed ? typed_rsp : pred);
	endtask

	// Hold valid low for a random burst; valid stays high otherwise
	task automatic sender_gap();
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		req_ch.valid <= 1'b0;
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (POST_DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_entity_limit(input logic [LIMIT_BITS-1:0] v);
		wait_drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		limit_reg = v;
	endtask

	task automatic run_random(input int n, input int lo, input int hi, input int idle);
		sset_req_t r;
		int pick;
		idle_pct = idle;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				r.func = FUNC_ADD;
			else if (pick < 50)
				r.func = FUNC_REMOVE;
			else if (pick < 62)
				r.func = FUNC_QUERY;
			else if (pick < 72)
				r.func = FUNC_CLEAR;
			else if (pick < 94)
				r.func = FUNC_COPY;
			else
				r.func = FUNC_BITS'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
			r.entity = ENT_IN_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
				: $urandom_range(lo, hi));
			r.source_entity = ENT_IN_BITS'(($urandom_range(0, 9) == 0)
				? $urandom_range(0, 4095) : $urandom_range(lo, hi));
			r.has_data = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 7))
				0: r.item_data = '0;
				1: r.item_data = '1;
				default: r.item_data = $urandom;
			endcase
			sender_gap();
			send_request(r, 1'b0, NO_RSP);
		end
	endtask

	initial begin
		sset_req_t r;
		int lim;
		int base;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_QUERY;
		req_ch.entity = '0;
		req_ch.source_entity = '0;
		req_ch.has_data = 1'b0;
		req_ch.item_data = '0;
		for (int i = 0; i < ENTITY_SLOTS; i++)
			sparse_map[i] = MAP_EMPTY;
		held = '0;
		limit_reg = LIMIT_BITS'(ENTITY_SLOTS);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 15;
		foreach (directed_rows[i]) begin
			sender_gap();
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
		end

		set_entity_limit(11'd1);
		run_random(40, 0, 3, 25);
		// zero limit rejects everything
		set_entity_limit(11'd0);
		run_random(20, 0, 8, 10);
		set_entity_limit(11'd2047);
		base = $urandom_range(0, 976);
		run_random(100, base, base + 47, 0);
		set_entity_limit(11'd16);
		run_random(100, 0, 20, 30);

		// grow the store, then shrink the limit under held entities
		set_entity_limit(11'd1024);
		idle_pct = 10;
		for (int i = 0; i < FILL_ITEMS; i++) begin
			r = '{FUNC_ADD, ENT_IN_BITS'(i), '0, 1'b1, $urandom};
			sender_gap();
			send_request(r, 1'b0, NO_RSP);
		end
		run_random(100, 0, 1023, 20);
		lim = $urandom_range(1, 1024);
		set_entity_limit(LIMIT_BITS'(lim));
		run_random(100, (lim > 30) ? lim - 30 : 0, lim + 4, 40);
		set_entity_limit(11'd64);
		run_random(70, 0, 70, 0);

		wait_drain();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
